>>> design/nnsag_pkg.sv
// Shared types and constants for the nearest-neighbor scaling address generator.
// No dependencies; nnsag_if, nnsag_csr and the top level use this package.
package nnsag_pkg;

   // register file geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int DIM_REG_W  = 13;
   localparam int BPP_REG_W  = 4;

   // result field widths
   localparam int ROW_W = 12;
   localparam int OFS_W = 15;

   // register indexes (byte address is 4 times the index)
   localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
   localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
   localparam logic [2:0] REG_BPP        = 3'd4;

   // raw register contents handed to the datapath
   typedef struct packed {
      logic [DIM_REG_W-1:0] src_width;
      logic [DIM_REG_W-1:0] src_height;
      logic [DIM_REG_W-1:0] dst_width;
      logic [DIM_REG_W-1:0] dst_height;
      logic [BPP_REG_W-1:0] bytes_per_pixel;
   } cfg_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_COL,
      ST_DIV_ROW,
      ST_EMIT
   } state_type;

endpackage

>>> design/nnsag_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on nnsag_pkg for the response field widths.
interface req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface rsp_if;
   logic                       valid;
   logic                       ready;
   logic [nnsag_pkg::ROW_W-1:0] src_row;
   logic [nnsag_pkg::OFS_W-1:0] src_byte_offset;
   logic [nnsag_pkg::ROW_W-1:0] dst_col;
   logic [nnsag_pkg::ROW_W-1:0] dst_row_index;
   logic                       row_end;
   logic                       frame_end;

   modport source (output valid, output src_row, output src_byte_offset, output dst_col,
                   output dst_row_index, output row_end, output frame_end, input ready);
   modport sink (input valid, input src_row, input src_byte_offset, input dst_col,
                 input dst_row_index, input row_end, input frame_end, output ready);
endinterface

>>> design/nnsag_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Standalone; used by the top level for both axis step computations.
module nnsag_div #(
   parameter int W = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CW = (W > 1) ? $clog2(W) : 1;

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic          fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      fits  = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? W'(trial - {1'b0, dvs_ff}) : W'(trial);
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

>>> design/nnsag_csr.sv
// APB-style configuration registers: image sizes and bytes per pixel.
// Depends on nnsag_pkg for the register map and the cfg_type struct.
module nnsag_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [nnsag_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [nnsag_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [nnsag_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                               pready,
   output nnsag_pkg::cfg_type                 cfg
);
   import nnsag_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SRC_WIDTH:  cfg_in.src_width       = pwdata[DIM_REG_W-1:0];
            REG_SRC_HEIGHT: cfg_in.src_height      = pwdata[DIM_REG_W-1:0];
            REG_DST_WIDTH:  cfg_in.dst_width       = pwdata[DIM_REG_W-1:0];
            REG_DST_HEIGHT: cfg_in.dst_height      = pwdata[DIM_REG_W-1:0];
            REG_BPP:        cfg_in.bytes_per_pixel = pwdata[BPP_REG_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_SRC_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.src_width);
         REG_SRC_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.src_height);
         REG_DST_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.dst_width);
         REG_DST_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.dst_height);
         REG_BPP:        prdata = CSR_DATA_W'(cfg_ff.bytes_per_pixel);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width       <= DIM_REG_W'(1);
         cfg_ff.src_height      <= DIM_REG_W'(1);
         cfg_ff.dst_width       <= DIM_REG_W'(1);
         cfg_ff.dst_height      <= DIM_REG_W'(1);
         cfg_ff.bytes_per_pixel <= BPP_REG_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> design/nearest_neighbor_scale_address_gen.sv
// Nearest-neighbor scaling address generator, top level.
// Depends on nnsag_pkg, nnsag_if, nnsag_csr and nnsag_div.
//
// Usage:
//   Each request beat on req_bus advances one destination pixel in raster
//   order and yields one response beat on rsp_bus carrying the source row,
//   the byte offset of the source pixel in that row, the destination column
//   and row, and end-of-row / end-of-frame flags. restart=1 drops the
//   current frame and starts again at destination pixel zero.
//   Sizes are programmed through the csr_ APB port (4-byte spaced registers)
//   and are sampled when a frame starts; program them only while idle.
// Timing:
//   Within a frame each pixel is accepted in ST_IDLE, then a step in ST_EMIT
//   loads the response register. The first beat of a frame additionally runs
//   two divisions on the shared one-bit-per-cycle divider.
//   req ready is high while the sequencer is idle, also while a response
//   still waits; if the receiver stalls, the step cycle holds until the
//   response register frees up, so nothing is dropped.
// Reset: synchronous; registers return to 1, no frame is active and the
//   response register is empty.
module nearest_neighbor_scale_address_gen #(
   parameter int MAX_DIM             = 4096,
   parameter int MAX_BYTES_PER_PIXEL = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   req_if.sink                              req_bus,
   rsp_if.source                            rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [nnsag_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [nnsag_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nnsag_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import nnsag_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int BPP_W  = $clog2(MAX_BYTES_PER_PIXEL + 1);
   localparam int SUM_W  = DIM_W + 1;
   localparam int PROD_W = CNT_W + BPP_W;
   localparam logic [31:0] MAX_DIM_L = 32'(MAX_DIM);
   localparam logic [31:0] MAX_BPP_L = 32'(MAX_BYTES_PER_PIXEL);

   function automatic logic [31:0] clamp_val(logic [31:0] v, logic [31:0] hi);
      logic [31:0] r;
      if (v == 32'd0) begin
         r = 32'd1;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   cfg_type cfg;

   logic [DIM_W-1:0] sw_c, sh_c, dw_c, dh_c;
   logic [BPP_W-1:0] bpp_c;

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] lat_dw_ff, lat_dw_in, lat_dh_ff, lat_dh_in;
   logic [BPP_W-1:0] lat_bpp_ff, lat_bpp_in;
   logic [DIM_W-1:0] step_col_ff, step_col_in, rem_col_ff, rem_col_in;
   logic [DIM_W-1:0] step_row_ff, step_row_in, rem_row_ff, rem_row_in;
   logic [CNT_W-1:0] col_cnt_ff, col_cnt_in, row_cnt_ff, row_cnt_in;
   logic [CNT_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [DIM_W-1:0] col_err_ff, col_err_in, row_err_ff, row_err_in;
   logic             frame_active_ff, frame_active_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] rsp_row_ff, rsp_col_ff, rsp_drow_ff;
   logic [OFS_W-1:0] rsp_ofs_ff;
   logic             rsp_rend_ff, rsp_fend_ff;

   logic             div_start, div_done;
   logic [DIM_W-1:0] div_dividend, div_divisor, div_quo, div_rem;

   logic             emit;
   logic [DIM_W-1:0] col_inc, row_inc;
   logic             row_end, frame_end;
   logic             col_hit, row_hit;
   logic [SUM_W-1:0] col_err_wrap, row_err_wrap, col_pos_sum, row_pos_sum;
   logic [PROD_W-1:0] byte_prod;

   nnsag_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   nnsag_div #(.W(DIM_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // clamp register values into the supported ranges
   assign sw_c  = DIM_W'(clamp_val(32'(cfg.src_width), MAX_DIM_L));
   assign sh_c  = DIM_W'(clamp_val(32'(cfg.src_height), MAX_DIM_L));
   assign dw_c  = DIM_W'(clamp_val(32'(cfg.dst_width), MAX_DIM_L));
   assign dh_c  = DIM_W'(clamp_val(32'(cfg.dst_height), MAX_DIM_L));
   assign bpp_c = BPP_W'(clamp_val(32'(cfg.bytes_per_pixel), MAX_BPP_L));

   // per-pixel stepping arithmetic
   always_comb begin
      col_inc      = DIM_W'(col_cnt_ff) + DIM_W'(1);
      row_inc      = DIM_W'(row_cnt_ff) + DIM_W'(1);
      row_end      = col_inc >= lat_dw_ff;
      frame_end    = row_end && (row_inc >= lat_dh_ff);
      col_hit      = col_err_ff <= rem_col_ff;
      row_hit      = row_err_ff <= rem_row_ff;
      col_err_wrap = SUM_W'(col_err_ff) + SUM_W'(lat_dw_ff) - SUM_W'(rem_col_ff);
      row_err_wrap = SUM_W'(row_err_ff) + SUM_W'(lat_dh_ff) - SUM_W'(rem_row_ff);
      col_pos_sum  = SUM_W'(src_col_ff) + SUM_W'(step_col_ff) + SUM_W'(col_hit);
      row_pos_sum  = SUM_W'(src_row_ff) + SUM_W'(step_row_ff) + SUM_W'(row_hit);
      byte_prod    = PROD_W'(src_col_ff) * PROD_W'(lat_bpp_ff);
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in        = state_ff;
      lat_dw_in       = lat_dw_ff;
      lat_dh_in       = lat_dh_ff;
      lat_bpp_in      = lat_bpp_ff;
      step_col_in     = step_col_ff;
      rem_col_in      = rem_col_ff;
      step_row_in     = step_row_ff;
      rem_row_in      = rem_row_ff;
      col_cnt_in      = col_cnt_ff;
      row_cnt_in      = row_cnt_ff;
      src_col_in      = src_col_ff;
      src_row_in      = src_row_ff;
      col_err_in      = col_err_ff;
      row_err_in      = row_err_ff;
      frame_active_in = frame_active_ff;
      div_start       = 1'b0;
      div_dividend    = sw_c;
      div_divisor     = dw_c;
      emit            = 1'b0;
      req_bus.ready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               if (!frame_active_ff || req_bus.restart) begin
                  // frame start: latch sizes, clear position, kick column division
                  lat_dw_in       = dw_c;
                  lat_dh_in       = dh_c;
                  lat_bpp_in      = bpp_c;
                  col_cnt_in      = '0;
                  row_cnt_in      = '0;
                  src_col_in      = '0;
                  src_row_in      = '0;
                  col_err_in      = dw_c;
                  row_err_in      = dh_c;
                  frame_active_in = 1'b1;
                  div_start       = 1'b1;
                  state_in        = ST_DIV_COL;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV_COL: begin
            div_dividend = sh_c;
            div_divisor  = lat_dh_ff;
            if (div_done) begin
               step_col_in = div_quo;
               rem_col_in  = div_rem;
               div_start   = 1'b1;
               state_in    = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            if (div_done) begin
               step_row_in = div_quo;
               rem_row_in  = div_rem;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (frame_end) begin
                  frame_active_in = 1'b0;
               end else if (row_end) begin
                  col_cnt_in = '0;
                  src_col_in = '0;
                  col_err_in = lat_dw_ff;
                  row_cnt_in = CNT_W'(row_inc);
                  src_row_in = CNT_W'(row_pos_sum);
                  row_err_in = row_hit ? DIM_W'(row_err_wrap) : row_err_ff - rem_row_ff;
               end else begin
                  col_cnt_in = CNT_W'(col_inc);
                  src_col_in = CNT_W'(col_pos_sum);
                  col_err_in = col_hit ? DIM_W'(col_err_wrap) : col_err_ff - rem_col_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_active_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         col_cnt_ff      <= '0;
         row_cnt_ff      <= '0;
         src_col_ff      <= '0;
         src_row_ff      <= '0;
      end else begin
         state_ff        <= state_in;
         frame_active_ff <= frame_active_in;
         rsp_valid_ff    <= rsp_valid_in;
         col_cnt_ff      <= col_cnt_in;
         row_cnt_ff      <= row_cnt_in;
         src_col_ff      <= src_col_in;
         src_row_ff      <= src_row_in;
      end
   end

   // frame parameters and error accumulators, always loaded before use
   always_ff @(posedge clock) begin
      lat_dw_ff   <= lat_dw_in;
      lat_dh_ff   <= lat_dh_in;
      lat_bpp_ff  <= lat_bpp_in;
      step_col_ff <= step_col_in;
      rem_col_ff  <= rem_col_in;
      step_row_ff <= step_row_in;
      rem_row_ff  <= rem_row_in;
      col_err_ff  <= col_err_in;
      row_err_ff  <= row_err_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff  <= ROW_W'(src_row_ff);
         rsp_ofs_ff  <= OFS_W'(byte_prod);
         rsp_col_ff  <= ROW_W'(col_cnt_ff);
         rsp_drow_ff <= ROW_W'(row_cnt_ff);
         rsp_rend_ff <= row_end;
         rsp_fend_ff <= frame_end;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.src_row         = rsp_row_ff;
   assign rsp_bus.src_byte_offset = rsp_ofs_ff;
   assign rsp_bus.dst_col         = rsp_col_ff;
   assign rsp_bus.dst_row_index   = rsp_drow_ff;
   assign rsp_bus.row_end         = rsp_rend_ff;
   assign rsp_bus.frame_end       = rsp_fend_ff;
endmodule

>>> design/nnsag_chk.sv
// Port-level checks for the scaling address generator, bound to the top level.
// Depends only on the top level's channel signals.
module nnsag_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_row_end,
   input logic rsp_frame_end
);
   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // the sequencer is busy in the cycle right after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // a result never shows up in the cycle right after its request
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared too early");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the last pixel of a frame also closes its row
   a_frame_closes_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");
endmodule

bind nearest_neighbor_scale_address_gen nnsag_chk u_nnsag_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_row_end   (rsp_bus.row_end),
   .rsp_frame_end (rsp_bus.frame_end)
);

>>> tb/tb_nearest_neighbor_scale_address_gen.sv
`timescale 1ns / 1ps
// Self-checking bench for the nearest-neighbor scaling address generator: an
// in-bench address model predicts every response beat across many size settings.
// Depends on nnsag_pkg, the req_if/rsp_if interfaces and the design top level.
module tb_nearest_neighbor_scale_address_gen;
   import nnsag_pkg::*;

   localparam int SIZE_LIMIT     = 4096;
   localparam int BPP_LIMIT      = 8;
   localparam int RANDOM_PHASES  = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;
   localparam int REPORT_CAP     = 60;
   // an index past the register file; writes to it must be dropped
   localparam logic [2:0] REG_UNMAPPED = 3'd5;

   typedef struct packed {
      logic [ROW_W-1:0] src_row;
      logic [OFS_W-1:0] src_byte_offset;
      logic [ROW_W-1:0] dst_col;
      logic [ROW_W-1:0] dst_row_index;
      logic             row_end;
      logic             frame_end;
   } addr_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   req_if req_bus ();
   rsp_if rsp_bus ();

   nearest_neighbor_scale_address_gen #(
      .MAX_DIM             (SIZE_LIMIT),
      .MAX_BYTES_PER_PIXEL (BPP_LIMIT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // stimulus and expectation stores
   logic          pixel_queue[$];
   addr_beat_type pending_addrs[$];
   bit            steady_mode = 1'b0;
   int            send_gap    = 0;
   int            recv_stall  = 0;
   int            quiet_cycles = 0;
   int            mismatch_count = 0;
   int            frames_seen = 0;
   int            restarts_seen = 0;
   int            settings_count = 0;

   // register copies as written
   logic [DIM_REG_W-1:0] cfg_src_w = 1;
   logic [DIM_REG_W-1:0] cfg_src_h = 1;
   logic [DIM_REG_W-1:0] cfg_dst_w = 1;
   logic [DIM_REG_W-1:0] cfg_dst_h = 1;
   logic [BPP_REG_W-1:0] cfg_bpp   = 1;

   // address model state; sizes latched at frame start
   int unsigned fr_dw = 0, fr_dh = 0, fr_bpp = 0;
   int unsigned col_step = 0, col_rem = 0, row_step = 0, row_rem = 0;
   int unsigned col_count = 0, row_count = 0, src_col = 0, src_row = 0;
   int          col_err = 0, row_err = 0;
   bit          in_frame = 1'b0;

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance one destination pixel and return the addresses it reads
   function automatic addr_beat_type step_pixel(input logic restart);
      addr_beat_type beat;
      int unsigned   sw, sh;
      if (!in_frame || restart) begin
         sw       = clamp_size(cfg_src_w, SIZE_LIMIT);
         sh       = clamp_size(cfg_src_h, SIZE_LIMIT);
         fr_dw    = clamp_size(cfg_dst_w, SIZE_LIMIT);
         fr_dh    = clamp_size(cfg_dst_h, SIZE_LIMIT);
         fr_bpp   = clamp_size(cfg_bpp, BPP_LIMIT);
         col_step = sw / fr_dw;
         col_rem  = sw % fr_dw;
         row_step = sh / fr_dh;
         row_rem  = sh % fr_dh;
         col_count = 0;
         row_count = 0;
         src_col   = 0;
         src_row   = 0;
         col_err   = fr_dw;
         row_err   = fr_dh;
         in_frame  = 1'b1;
      end
      beat.row_end         = (col_count + 1 >= fr_dw);
      beat.frame_end       = beat.row_end && (row_count + 1 >= fr_dh);
      beat.src_row         = ROW_W'(src_row);
      beat.src_byte_offset = OFS_W'(src_col * fr_bpp);
      beat.dst_col         = ROW_W'(col_count);
      beat.dst_row_index   = ROW_W'(row_count);

      if (beat.frame_end) begin
         in_frame = 1'b0;
      end else if (beat.row_end) begin
         // next row: column restarts, row steps with remainder carry
         col_count = 0;
         src_col   = 0;
         col_err   = fr_dw;
         row_count++;
         src_row += row_step;
         row_err -= row_rem;
         if (row_err <= 0) begin
            row_err += fr_dh;
            src_row++;
         end
      end else begin
         col_count++;
         src_col += col_step;
         col_err -= col_rem;
         if (col_err <= 0) begin
            col_err += fr_dw;
            src_col++;
         end
      end
      return beat;
   endfunction

   // mostly short gaps, a few long ones, none in steady phases
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_mode || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_CAP)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // request driver; the model steps on every accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.restart <= 1'b0;
         send_gap        <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_addrs.push_back(step_pixel(req_bus.restart));
            if (req_bus.restart) restarts_seen++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               req_bus.valid <= 1'b0;
               send_gap      <= send_gap - 1;
            end else if (pixel_queue.size() != 0) begin
               req_bus.valid   <= 1'b1;
               req_bus.restart <= pixel_queue.pop_front();
               send_gap        <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random backpressure
   always @(posedge clock) begin : rsp_monitor
      addr_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_addrs.size() == 0) begin
               mismatch_count++;
               $error("response beat with no expectation pending");
            end else begin
               want = pending_addrs.pop_front();
               compare_field("src_row", want.src_row, rsp_bus.src_row);
               compare_field("src_byte_offset", want.src_byte_offset, rsp_bus.src_byte_offset);
               compare_field("dst_col", want.dst_col, rsp_bus.dst_col);
               compare_field("dst_row_index", want.dst_row_index, rsp_bus.dst_row_index);
               compare_field("row_end", want.row_end, rsp_bus.row_end);
               compare_field("frame_end", want.frame_end, rsp_bus.frame_end);
               if (want.frame_end) frames_seen++;
            end
         end
         if (recv_stall != 0) begin
            rsp_bus.ready <= 1'b0;
            recv_stall    <= recv_stall - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            recv_stall    <= pick_gap();
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // APB write: setup then access; the model copy follows the same masking
   task automatic write_reg(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_SRC_WIDTH:  cfg_src_w = data[DIM_REG_W-1:0];
         REG_SRC_HEIGHT: cfg_src_h = data[DIM_REG_W-1:0];
         REG_DST_WIDTH:  cfg_dst_w = data[DIM_REG_W-1:0];
         REG_DST_HEIGHT: cfg_dst_h = data[DIM_REG_W-1:0];
         REG_BPP:        cfg_bpp   = data[BPP_REG_W-1:0];
         default: ;
      endcase
   endtask

   // random junk above the field width checks the register masking
   function automatic logic [CSR_DATA_W-1:0] with_junk(input int unsigned value,
                                                       input int unsigned field_w);
      logic [CSR_DATA_W-1:0] junk;
      junk = ($urandom_range(0, 3) == 0) ? $urandom() : 0;
      return ((junk >> field_w) << field_w) | value;
   endfunction

   task automatic program_sizes(input int unsigned sw, input int unsigned sh,
                                input int unsigned dw, input int unsigned dh,
                                input int unsigned bpp);
      write_reg(REG_SRC_WIDTH, with_junk(sw, DIM_REG_W));
      write_reg(REG_SRC_HEIGHT, with_junk(sh, DIM_REG_W));
      write_reg(REG_DST_WIDTH, with_junk(dw, DIM_REG_W));
      write_reg(REG_DST_HEIGHT, with_junk(dh, DIM_REG_W));
      write_reg(REG_BPP, with_junk(bpp, BPP_REG_W));
      settings_count++;
   endtask

   task automatic queue_pixels(input int count, input int restart_pct);
      @(negedge clock);
      repeat (count) pixel_queue.push_back($urandom_range(0, 99) < restart_pct);
   endtask

   // hold off until every beat is sent and answered, then let the block settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_bus.valid || pending_addrs.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic int unsigned pick_size(input int unsigned common_hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom_range(0, (1 << DIM_REG_W) - 1);
      if (r == 1) return $urandom_range(SIZE_LIMIT - 2, SIZE_LIMIT + 1);
      return $urandom_range(1, common_hi);
   endfunction

   initial begin
      int ph;
      int unsigned sw, sh, dw, dh;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: every pixel is a one-pixel frame
      queue_pixels(1, 0);
      queue_pixels(1, 100);
      wait_drained();

      // downscale with remainders on both axes, bpp above the limit; one wrap
      program_sizes(13, 7, 5, 3, 15);
      queue_pixels(16, 0);
      wait_drained();

      // zero and oversized registers, dropped write, restart mid-row
      program_sizes(0, (1 << DIM_REG_W) - 1, (1 << DIM_REG_W) - 1, 0, 0);
      write_reg(REG_UNMAPPED, 32'h0000_0003);
      queue_pixels(2, 0);
      queue_pixels(1, 100);
      queue_pixels(1, 0);
      wait_drained();

      // single-column destination: every pixel ends a row
      program_sizes(SIZE_LIMIT - 1, SIZE_LIMIT, 1, 2, BPP_LIMIT);
      queue_pixels(3, 0);
      wait_drained();

      // random settings, mostly small destinations so frames complete
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         steady_mode = (ph % 4 == 1);
         sw = pick_size(64);
         sh = pick_size(64);
         dw = ($urandom_range(0, 7) == 0) ? pick_size(SIZE_LIMIT) : $urandom_range(1, 24);
         dh = ($urandom_range(0, 7) == 0) ? pick_size(SIZE_LIMIT) : $urandom_range(1, 16);
         program_sizes(sw, sh, dw, dh, $urandom_range(0, (1 << BPP_REG_W) - 1));
         if (ph % 5 == 2) write_reg(3'(REG_UNMAPPED + ph % 3), $urandom());
         queue_pixels($urandom_range(100, 180), (ph == 3) ? 35 : 2);
         wait_drained();
      end
      steady_mode = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_addrs.size() != 0) begin
         mismatch_count++;
         $error("%0d expected response beats never arrived", pending_addrs.size());
      end
      $display("Ran %0d size settings: %0d frames completed, %0d restarts, %0d mismatches.",
               settings_count, frames_seen, restarts_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
